>>> rtl/nearest_neighbor_tour_defines.svh
// Assertion helpers shared by the tour block.
`ifndef NEAREST_NEIGHBOR_TOUR_DEFINES_SVH
`define NEAREST_NEIGHBOR_TOUR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define NNT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define NNT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/nnt_pkg.sv
`timescale 1ns / 1ps

package nnt_pkg;

   localparam int MAX_POINTS = 64;
   localparam int COORD_BITS = 10;
   localparam int IDX_BITS   = $clog2(MAX_POINTS);
   localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
   localparam int START_BITS = 6;
   localparam int DIFF_BITS  = COORD_BITS;
   localparam int SQ_BITS    = 2 * COORD_BITS;
   localparam int DIST_BITS  = SQ_BITS + 1;

   // Register map
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic CSR_SEL_START_INDEX = 1'b0;

   typedef struct packed {
      logic [COORD_BITS-1:0] point_x;
      logic [COORD_BITS-1:0] point_y;
      logic                  last_point;
   } req_type;

   typedef struct packed {
      logic [IDX_BITS-1:0]   tour_position;
      logic [IDX_BITS-1:0]   point_index;
      logic [COORD_BITS-1:0] visit_x;
      logic [COORD_BITS-1:0] visit_y;
      logic                  tour_end;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_FETCH = 4'b0010,
      ST_EMIT  = 4'b0100,
      ST_SCAN  = 4'b1000
   } state_type;

endpackage

>>> rtl/nnt_ram.sv
`timescale 1ns / 1ps

module nnt_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/nearest_neighbor_tour.sv
// Loading: one item per cycle while idle, until the item marked last starts the tour.
// Tour: each step scans every loaded point through one shared distance pipeline fed by
// the RAM read port; visited points are read but not compared.
// After the last item, FETCH then EMIT give the first result; no new item until done.
// Reset: synchronous, clears control, start_index and visited marks.
`timescale 1ns / 1ps
`include "nearest_neighbor_tour_defines.svh"

module nearest_neighbor_tour (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  nnt_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output nnt_pkg::rsp_type                 rsp_data,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [nnt_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [nnt_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [nnt_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                             csr_pready
);

   localparam int PW = 2 * nnt_pkg::COORD_BITS;

   nnt_pkg::state_type                state_ff, state_in;
   logic [nnt_pkg::START_BITS-1:0]    start_ff, start_in;
   logic [nnt_pkg::CNT_BITS-1:0]      loaded_ff, loaded_in;
   logic [nnt_pkg::CNT_BITS-1:0]      count_ff, count_in;
   logic [nnt_pkg::CNT_BITS-1:0]      pos_ff, pos_in;
   logic [nnt_pkg::CNT_BITS-1:0]      scan_ff, scan_in;
   logic [nnt_pkg::IDX_BITS-1:0]      cur_ff, cur_in;
   logic [nnt_pkg::COORD_BITS-1:0]    cur_x_ff, cur_x_in;
   logic [nnt_pkg::COORD_BITS-1:0]    cur_y_ff, cur_y_in;
   logic [nnt_pkg::MAX_POINTS-1:0]    visited_ff, visited_in;
   logic                              found_ff, found_in;
   logic [nnt_pkg::IDX_BITS-1:0]      best_ff, best_in;
   logic [nnt_pkg::DIST_BITS-1:0]     best_d_ff, best_d_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   nnt_pkg::rsp_type                  rsp_ff, rsp_in;

   // Distance pipeline
   logic                              p0_valid_ff, p0_valid_in;
   logic [nnt_pkg::IDX_BITS-1:0]      p0_idx_ff;
   logic                              p1_valid_ff, p1_valid_in;
   logic [nnt_pkg::IDX_BITS-1:0]      p1_idx_ff;
   logic [nnt_pkg::DIFF_BITS-1:0]     dx_ff, dx_in, dy_ff, dy_in;
   logic                              p2_valid_ff, p2_valid_in;
   logic [nnt_pkg::IDX_BITS-1:0]      p2_idx_ff;
   logic [nnt_pkg::SQ_BITS-1:0]       sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [nnt_pkg::DIST_BITS-1:0]     sum_sq;

   logic                              req_accept;
   logic                              csr_write;
   logic                              ram_wr_en;
   logic [nnt_pkg::IDX_BITS-1:0]      ram_rd_addr;
   logic [PW-1:0]                     ram_rd_data;
   logic [nnt_pkg::COORD_BITS-1:0]    rd_x, rd_y;
   logic                              issue;
   logic                              scan_done;
   logic                              rsp_load;
   logic [nnt_pkg::CNT_BITS-1:0]      pos_next;
   logic [nnt_pkg::CNT_BITS-1:0]      new_count;
   logic                              is_end;

   // Config port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign start_in   = (csr_write && csr_paddr[2] == nnt_pkg::CSR_SEL_START_INDEX) ?
                       csr_pwdata[nnt_pkg::START_BITS-1:0] : start_ff;
   assign csr_prdata = (csr_paddr[2] == nnt_pkg::CSR_SEL_START_INDEX) ?
                       nnt_pkg::CSR_DATA_BITS'(start_ff) : '0;

   // Handshakes
   assign req_stall  = (state_ff != nnt_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // Point store
   assign ram_wr_en = req_accept &&
                      (loaded_ff < nnt_pkg::CNT_BITS'(nnt_pkg::MAX_POINTS));
   assign ram_rd_addr = (state_ff == nnt_pkg::ST_SCAN) ?
                        scan_ff[nnt_pkg::IDX_BITS-1:0] : cur_ff;

   nnt_ram #(
      .WIDTH (PW),
      .DEPTH (nnt_pkg::MAX_POINTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (loaded_ff[nnt_pkg::IDX_BITS-1:0]),
      .wr_data ({req_data.point_x, req_data.point_y}),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_x = ram_rd_data[PW-1:nnt_pkg::COORD_BITS];
   assign rd_y = ram_rd_data[nnt_pkg::COORD_BITS-1:0];

   // Shared distance unit: abs diff, square, sum
   assign dx_in  = (rd_x > cur_x_ff) ? rd_x - cur_x_ff : cur_x_ff - rd_x;
   assign dy_in  = (rd_y > cur_y_ff) ? rd_y - cur_y_ff : cur_y_ff - rd_y;
   assign sqx_in = nnt_pkg::SQ_BITS'(dx_ff) * nnt_pkg::SQ_BITS'(dx_ff);
   assign sqy_in = nnt_pkg::SQ_BITS'(dy_ff) * nnt_pkg::SQ_BITS'(dy_ff);
   assign sum_sq = nnt_pkg::DIST_BITS'(sqx_ff) + nnt_pkg::DIST_BITS'(sqy_ff);

   assign issue       = (state_ff == nnt_pkg::ST_SCAN) && (scan_ff < count_ff);
   assign p0_valid_in = issue && !visited_ff[scan_ff[nnt_pkg::IDX_BITS-1:0]];
   assign p1_valid_in = p0_valid_ff;
   assign p2_valid_in = p1_valid_ff;
   assign scan_done   = (state_ff == nnt_pkg::ST_SCAN) && !issue &&
                        !p0_valid_ff && !p1_valid_ff && !p2_valid_ff;

   assign pos_next  = pos_ff + nnt_pkg::CNT_BITS'(1);
   assign is_end    = (pos_next == count_ff);
   assign rsp_load  = (state_ff == nnt_pkg::ST_EMIT) && (!rsp_valid_ff || !rsp_stall);
   assign new_count = loaded_ff + (ram_wr_en ? nnt_pkg::CNT_BITS'(1) : '0);

   // Result payload
   always_comb begin
      rsp_in               = rsp_ff;
      rsp_in.tour_position = pos_ff[nnt_pkg::IDX_BITS-1:0];
      rsp_in.point_index   = cur_ff;
      rsp_in.visit_x       = rd_x;
      rsp_in.visit_y       = rd_y;
      rsp_in.tour_end      = is_end;
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      loaded_in  = loaded_ff;
      count_in   = count_ff;
      pos_in     = pos_ff;
      scan_in    = scan_ff;
      cur_in     = cur_ff;
      cur_x_in   = cur_x_ff;
      cur_y_in   = cur_y_ff;
      visited_in = visited_ff;
      found_in   = found_ff;
      best_in    = best_ff;
      best_d_in  = best_d_ff;
      case (state_ff)
         nnt_pkg::ST_IDLE: begin
            if (req_accept) begin
               loaded_in = new_count;
               if (req_data.last_point) begin
                  count_in   = new_count;
                  pos_in     = '0;
                  visited_in = '0;
                  cur_in     = (nnt_pkg::CNT_BITS'(start_ff) < new_count) ?
                               nnt_pkg::IDX_BITS'(start_ff) : '0;
                  state_in   = nnt_pkg::ST_FETCH;
               end
            end
         end
         nnt_pkg::ST_FETCH: begin
            state_in = nnt_pkg::ST_EMIT;
         end
         nnt_pkg::ST_EMIT: begin
            if (rsp_load) begin
               visited_in[cur_ff] = 1'b1;
               cur_x_in = rd_x;
               cur_y_in = rd_y;
               pos_in   = pos_next;
               scan_in  = '0;
               found_in = 1'b0;
               if (is_end) begin
                  loaded_in = '0;
                  state_in  = nnt_pkg::ST_IDLE;
               end else begin
                  state_in  = nnt_pkg::ST_SCAN;
               end
            end
         end
         nnt_pkg::ST_SCAN: begin
            if (issue) begin
               scan_in = scan_ff + nnt_pkg::CNT_BITS'(1);
            end
            // Strict compare in index order keeps the lowest index on ties
            if (p2_valid_ff && (!found_ff || sum_sq < best_d_ff)) begin
               found_in  = 1'b1;
               best_in   = p2_idx_ff;
               best_d_in = sum_sq;
            end
            if (scan_done) begin
               cur_in   = best_ff;
               state_in = nnt_pkg::ST_FETCH;
            end
         end
         default: begin
            state_in = nnt_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nnt_pkg::ST_IDLE;
         start_ff     <= '0;
         loaded_ff    <= '0;
         count_ff     <= '0;
         pos_ff       <= '0;
         scan_ff      <= '0;
         cur_ff       <= '0;
         visited_ff   <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         p0_valid_ff  <= 1'b0;
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         loaded_ff    <= loaded_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         scan_ff      <= scan_in;
         cur_ff       <= cur_in;
         visited_ff   <= visited_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         p0_valid_ff  <= p0_valid_in;
         p1_valid_ff  <= p1_valid_in;
         p2_valid_ff  <= p2_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_x_ff  <= cur_x_in;
      cur_y_ff  <= cur_y_in;
      best_ff   <= best_in;
      best_d_ff <= best_d_in;
      p0_idx_ff <= scan_ff[nnt_pkg::IDX_BITS-1:0];
      p1_idx_ff <= p0_idx_ff;
      p2_idx_ff <= p1_idx_ff;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      sqx_ff    <= sqx_in;
      sqy_ff    <= sqy_in;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   // Checks
   `NNT_ASSERT_NOW(a_visited_matches_pos, clock, reset, state_ff == nnt_pkg::ST_SCAN, $countones(visited_ff) == pos_ff, "visited marks out of step with tour position")
   `NNT_ASSERT_NOW(a_scan_found_one, clock, reset, scan_done, found_ff, "scan ended without a candidate")
   `NNT_ASSERT_NEXT(a_end_clears_load, clock, reset, rsp_load && is_end, loaded_ff == '0 && state_ff == nnt_pkg::ST_IDLE, "tour end did not release the point set")

endmodule
